// ===== design/order_id_table_update_unit_macros.svh =====
// Assertion macros for the order id table update unit.
`ifndef ORDER_ID_TABLE_UPDATE_UNIT_MACROS_SVH
`define ORDER_ID_TABLE_UPDATE_UNIT_MACROS_SVH

`ifndef SYNTH
`define OIDT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("oidt assertion failed");
`define OIDT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("oidt assertion failed");
`else
`define OIDT_ASSERT(name, clk, rst_n, prop)
`define OIDT_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== design/oidt_pkg.sv =====
package oidt_pkg;

  localparam int unsigned OPC_W    = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TOKEN_W  = 32;
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned QTY_W    = 32;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned STATUS_W = 3;

  localparam logic [OPC_W-1:0] OP_NEW    = 3'd0;
  localparam logic [OPC_W-1:0] OP_MODIFY = 3'd1;
  localparam logic [OPC_W-1:0] OP_CANCEL = 3'd2;
  localparam logic [OPC_W-1:0] OP_TRADE  = 3'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REDUCED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd6;

endpackage

// ===== design/oidt_in_if.sv =====
interface oidt_in_if import oidt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OPC_W-1:0]          opcode;
  logic [KEY_W-1:0]          order_key;
  logic [TOKEN_W-1:0]        instrument_token;
  logic [KIND_W-1:0]         order_kind;
  logic signed [PRICE_W-1:0] order_price;
  logic [QTY_W-1:0]          order_qty;
  logic [SEQ_W-1:0]          seq_number;

  modport source (
    output valid, opcode, order_key, instrument_token, order_kind, order_price,
           order_qty, seq_number,
    input  ready
  );

  modport sink (
    input  valid, opcode, order_key, instrument_token, order_kind, order_price,
           order_qty, seq_number,
    output ready
  );
endinterface

// ===== design/oidt_out_if.sv =====
interface oidt_out_if import oidt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [QTY_W-1:0]    remaining_qty;
  logic [SEQ_W-1:0]    last_seq;

  modport source (
    output valid, status, remaining_qty, last_seq,
    input  ready
  );

  modport sink (
    input  valid, status, remaining_qty, last_seq,
    output ready
  );
endinterface

// ===== design/order_id_table_update_unit.sv =====
// A transaction is held in the input stage registers, then its result in the result registers.
// Throughput: one transaction per cycle while the result port is not stalled; the
// parallel key match and update of the whole table lie between input and result registers.
// Reset (asynchronous, active low) clears all valid marks and the control
// state; stored order fields are not reset.
`include "order_id_table_update_unit_macros.svh"

module order_id_table_update_unit import oidt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oidt_in_if.sink    in_i,
  oidt_out_if.source out_o
);

  logic                      s1_valid_q;
  logic [OPC_W-1:0]          s1_opcode_q;
  logic [KEY_W-1:0]          s1_key_q;
  logic [TOKEN_W-1:0]        s1_token_q;
  logic [KIND_W-1:0]         s1_kind_q;
  logic signed [PRICE_W-1:0] s1_price_q;
  logic [QTY_W-1:0]          s1_qty_q;
  logic [SEQ_W-1:0]          s1_seq_q;

  logic                      out_valid_q;
  logic [STATUS_W-1:0]       status_q;
  logic [QTY_W-1:0]          remain_q;
  logic [SEQ_W-1:0]          seq_q;

  logic [TABLE_DEPTH-1:0]    valid_q;
  logic [TABLE_DEPTH-1:0]    valid_d;
  logic [KEY_W-1:0]          key_q   [TABLE_DEPTH];
  logic [TOKEN_W-1:0]        token_q [TABLE_DEPTH];
  logic [KIND_W-1:0]         kind_q  [TABLE_DEPTH];
  logic signed [PRICE_W-1:0] price_q [TABLE_DEPTH];
  logic [QTY_W-1:0]          qty_q   [TABLE_DEPTH];

  logic                      adv;
  logic                      in_ready;
  logic                      in_fire;
  logic                      s1_fire;
  logic [TABLE_DEPTH-1:0]    match;
  logic [TABLE_DEPTH-1:0]    free_oh;
  logic                      hit;
  logic                      have_free;
  logic [QTY_W-1:0]          hit_qty;
  logic [TABLE_DEPTH-1:0]    wr_sel;
  logic [TABLE_DEPTH-1:0]    clr_sel;
  logic [TABLE_DEPTH-1:0]    red_sel;
  logic [STATUS_W-1:0]       status_d;
  logic [QTY_W-1:0]          remain_d;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_ready   = !s1_valid_q || adv;
  assign in_fire    = in_i.valid && in_ready;
  assign s1_fire    = s1_valid_q && adv;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_opcode_q <= in_i.opcode;
      s1_key_q    <= in_i.order_key;
      s1_token_q  <= in_i.instrument_token;
      s1_kind_q   <= in_i.order_kind;
      s1_price_q  <= in_i.order_price;
      s1_qty_q    <= in_i.order_qty;
      s1_seq_q    <= in_i.seq_number;
    end
  end

  always_comb begin
    hit_qty = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = valid_q[i] && (key_q[i] == s1_key_q);
      hit_qty  = hit_qty | (match[i] ? qty_q[i] : '0);
    end
  end

  assign hit       = |match;
  assign have_free = ~&valid_q;
  assign free_oh   = ~valid_q & (valid_q + TABLE_DEPTH'(1));

  always_comb begin
    status_d = ST_IGNORED;
    remain_d = '0;
    wr_sel   = '0;
    clr_sel  = '0;
    red_sel  = '0;
    case (s1_opcode_q)
      OP_NEW, OP_MODIFY: begin
        if (hit) begin
          status_d = ST_OVERWRITTEN;
          wr_sel   = match;
          remain_d = s1_qty_q;
        end else if (have_free) begin
          status_d = ST_INSERTED;
          wr_sel   = free_oh;
          remain_d = s1_qty_q;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_CANCEL: begin
        if (hit) begin
          status_d = ST_REMOVED;
          clr_sel  = match;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_TRADE: begin
        if (!hit) begin
          status_d = ST_NOT_FOUND;
        end else if (s1_qty_q >= hit_qty) begin
          status_d = ST_REMOVED;
          clr_sel  = match;
        end else begin
          status_d = ST_REDUCED;
          red_sel  = match;
          remain_d = hit_qty - s1_qty_q;
        end
      end
      default: begin
        status_d = ST_IGNORED;
        remain_d = hit_qty;
      end
    endcase
  end

  assign valid_d = (valid_q | wr_sel) & ~clr_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (s1_fire) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (s1_fire && wr_sel[i]) begin
        key_q[i]   <= s1_key_q;
        token_q[i] <= s1_token_q;
        kind_q[i]  <= s1_kind_q;
        price_q[i] <= s1_price_q;
        qty_q[i]   <= s1_qty_q;
      end else if (s1_fire && red_sel[i]) begin
        qty_q[i]   <= remain_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q <= status_d;
      remain_q <= remain_d;
      seq_q    <= s1_seq_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.remaining_qty = remain_q;
  assign out_o.last_seq      = seq_q;

  `OIDT_ASSERT(a_key_unique, clk_i, rst_ni, $onehot0(match))
  `OIDT_ASSERT_ALWAYS(a_single_write, clk_i, $onehot0(wr_sel | clr_sel | red_sel))
  `OIDT_ASSERT(a_full_only_when_full, clk_i, rst_ni, s1_fire && status_d == ST_FULL |-> &valid_q)
  `OIDT_ASSERT(a_stall_holds_item, clk_i, rst_ni, s1_valid_q && !adv |=> s1_valid_q)

endmodule

// ===== tb/sv/order_book_checker.sv =====
module order_book_checker import oidt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  oidt_in_if   orders_i,
  oidt_out_if  results_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QTY_W-1:0]    remaining_qty;
    logic [SEQ_W-1:0]    last_seq;
  } book_result_t;

  logic             slot_live [TABLE_DEPTH];
  logic [KEY_W-1:0] slot_key  [TABLE_DEPTH];
  logic [QTY_W-1:0] slot_qty  [TABLE_DEPTH];
  book_result_t     awaited_q [$];

  function automatic book_result_t apply_order(input logic [OPC_W-1:0] op,
                                               input logic [KEY_W-1:0] key,
                                               input logic [QTY_W-1:0] qty,
                                               input logic [SEQ_W-1:0] seq);
    book_result_t res;
    int           hit;
    int           slot;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_live[i] && slot_key[i] == key && hit < 0) hit = i;
      if (!slot_live[i] && slot < 0) slot = i;
    end
    res.remaining_qty = '0;
    res.last_seq      = seq;
    if (op == OP_NEW || op == OP_MODIFY) begin
      if (hit >= 0) begin
        res.status = ST_OVERWRITTEN;
        slot       = hit;
      end else begin
        res.status = (slot >= 0) ? ST_INSERTED : ST_FULL;
      end
      if (slot >= 0) begin
        slot_live[slot]   = 1'b1;
        slot_key[slot]    = key;
        slot_qty[slot]    = qty;
        res.remaining_qty = qty;
      end
    end else if (op == OP_CANCEL) begin
      if (hit >= 0) begin
        slot_live[hit] = 1'b0;
        res.status     = ST_REMOVED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else if (op == OP_TRADE) begin
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else if (qty >= slot_qty[hit]) begin
        slot_live[hit] = 1'b0;
        res.status     = ST_REMOVED;
      end else begin
        slot_qty[hit]     = slot_qty[hit] - qty;
        res.remaining_qty = slot_qty[hit];
        res.status        = ST_REDUCED;
      end
    end else begin
      res.status = ST_IGNORED;
      if (hit >= 0) res.remaining_qty = slot_qty[hit];
    end
    return res;
  endfunction

  task automatic compare_result(input book_result_t want);
    if (results_i.status !== want.status) begin
      mismatches_o++;
      $display("%0t: status expected %0d, got %0d", $time, want.status, results_i.status);
    end
    if (results_i.remaining_qty !== want.remaining_qty) begin
      mismatches_o++;
      $display("%0t: remaining_qty expected %0d, got %0d", $time, want.remaining_qty,
               results_i.remaining_qty);
    end
    if (results_i.last_seq !== want.last_seq) begin
      mismatches_o++;
      $display("%0t: last_seq expected 0x%08h, got 0x%08h", $time, want.last_seq,
               results_i.last_seq);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
      awaited_q.delete();
      pending_o = 0;
    end else begin
      if (results_i.valid === 1'b1 && results_i.ready === 1'b1) begin
        if (awaited_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: result expected none, got status %0d qty %0d seq 0x%08h", $time,
                   results_i.status, results_i.remaining_qty, results_i.last_seq);
        end else begin
          compare_result(awaited_q.pop_front());
          checked_o++;
        end
      end
      if (orders_i.valid === 1'b1 && orders_i.ready === 1'b1) begin
        awaited_q.insert(awaited_q.size(),
                         apply_order(orders_i.opcode, orders_i.order_key,
                                     orders_i.order_qty, orders_i.seq_number));
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import oidt_pkg::*;

  localparam int unsigned BOOK_DEPTH  = 64;
  localparam int          KEY_POOL    = 100;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 150;

  localparam logic [OPC_W-1:0] OP_OTHER = 3'd4;
  localparam logic [OPC_W-1:0] OP_LAST  = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  int               send_idle_pct;
  int               stall_pct;
  int               hold_left;
  int               sent_count;
  int               mismatches;
  int               pending;
  int               checked;
  logic [SEQ_W-1:0] seq_next;
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  int send_idle_tbl [PHASES] = '{0, 58, 0, 16, 0, 16};
  int stall_tbl     [PHASES] = '{0, 0, 58, 16, 0, 16};
  int new_tbl       [PHASES] = '{60, 70, 35, 50, 55, 40};
  int hold_tbl      [PHASES] = '{0, 0, 0, 0, 40, 0};

  oidt_in_if  order_in ();
  oidt_out_if result_out ();

  order_id_table_update_unit #(.TABLE_DEPTH(BOOK_DEPTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (order_in),
    .out_o  (result_out)
  );

  order_book_checker #(.TABLE_DEPTH(BOOK_DEPTH)) book_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .orders_i     (order_in),
    .results_i    (result_out),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 500_000);
    $display("FAIL order_id_table_update_unit");
    $finish;
  end

  initial begin
    result_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        result_out.ready = 1'b0;
        hold_left--;
      end else begin
        result_out.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_order(input logic [OPC_W-1:0] op,
                            input logic [KEY_W-1:0] key,
                            input logic [TOKEN_W-1:0] token,
                            input logic [KIND_W-1:0] kind,
                            input logic signed [PRICE_W-1:0] price,
                            input logic [QTY_W-1:0] qty);
    while ($urandom_range(99) < send_idle_pct) begin
      order_in.valid = 1'b0;
      @(negedge clk_i);
    end
    order_in.opcode           = op;
    order_in.order_key        = key;
    order_in.instrument_token = token;
    order_in.order_kind       = kind;
    order_in.order_price      = price;
    order_in.order_qty        = qty;
    order_in.seq_number       = seq_next;
    order_in.valid            = 1'b1;
    do @(posedge clk_i); while (order_in.ready !== 1'b1);
    sent_count++;
    seq_next = seq_next + $urandom_range(3, 1);
    @(negedge clk_i);
  endtask

  task automatic send_random_order(input int new_pct);
    int               pick;
    logic [OPC_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [QTY_W-1:0] qty;
    pick = $urandom_range(99);
    if (pick < new_pct) begin
      op = ($urandom_range(3) == 0) ? OP_MODIFY : OP_NEW;
    end else begin
      pick = $urandom_range(99);
      if (pick < 35) op = OP_CANCEL;
      else if (pick < 85) op = OP_TRADE;
      else op = OPC_W'($urandom_range(OP_LAST, OP_OTHER));
    end
    key = ($urandom_range(19) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(KEY_POOL - 1)];
    case ($urandom_range(9))
      0: qty = $urandom;
      1: qty = '0;
      default: qty = (op == OP_TRADE) ? $urandom_range(600, 1) : $urandom_range(1000, 1);
    endcase
    if ($urandom_range(15) == 0) seq_next = $urandom;
    send_order(op, key, $urandom, KIND_W'($urandom), $urandom, qty);
  endtask

  initial begin
    rst_ni                    = 1'b0;
    order_in.valid            = 1'b0;
    order_in.opcode           = OP_NEW;
    order_in.order_key        = '0;
    order_in.instrument_token = '0;
    order_in.order_kind       = '0;
    order_in.order_price      = '0;
    order_in.order_qty        = '0;
    order_in.seq_number       = '0;
    send_idle_pct             = 0;
    stall_pct                 = 0;
    hold_left                 = 0;
    sent_count                = 0;
    seq_next                  = '0;
    key_pool[0]               = '0;
    key_pool[1]               = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_order(OP_OTHER, 32'h0000_1234, '0, '0, '0, 32'd9);
    send_order(OP_CANCEL, 32'h0000_1234, '0, '0, '0, '0);
    send_order(OP_TRADE, 32'h0000_1234, '0, '0, '0, 32'd5);
    send_order(OP_NEW, '0, '0, '0, 32'h8000_0000, '1);
    seq_next = '1;
    send_order(OP_NEW, '1, '1, '1, 32'h7fff_ffff, '0);
    send_order(OP_MODIFY, '0, 32'h0bad_cafe, 8'h4d, -32'sd17, 32'd1000);
    send_order(OP_NEW, '0, 32'h1357_9bdf, 8'h4e, 32'sd250, 32'd1000);
    send_order(OP_TRADE, '0, '0, '0, '0, '0);
    send_order(OP_TRADE, '0, '0, '0, '0, 32'd400);
    for (int code = OP_OTHER; code <= OP_LAST; code++) begin
      send_order(OPC_W'(code), '0, '0, '0, '0, 32'd77);
    end
    send_order(OP_TRADE, '0, '0, '0, '0, 32'd600);
    send_order(OP_TRADE, '1, '0, '0, '0, '0);
    send_order(OP_MODIFY, 32'd5, 32'd11, 8'h4d, 32'sd100, 32'd7);
    send_order(OP_NEW, 32'd6, 32'd12, 8'h4e, 32'sd101, 32'd10);
    send_order(OP_TRADE, 32'd6, '0, '0, '0, '1);
    send_order(OP_CANCEL, 32'd5, '0, '0, '0, '0);
    send_order(OP_CANCEL, 32'd5, '0, '0, '0, '0);
    send_order(OP_NEW, 32'd7, 32'd13, 8'h54, -32'sd1, 32'd3);
    send_order(OP_OTHER, 32'd7, '0, '0, '0, '0);
    order_in.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = send_idle_tbl[p];
      stall_pct     = stall_tbl[p];
      hold_left     = hold_tbl[p];
      repeat (PHASE_ITEMS) send_random_order(new_tbl[p]);
      order_in.valid = 1'b0;
      wait (pending == 0);
      @(negedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d order transactions: directed edge cases, then %0d traffic phases",
             sent_count, PHASES);
    $display("with table-full churn and a long result hold-off; %0d results compared",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS order_id_table_update_unit");
    end else begin
      $display("FAIL order_id_table_update_unit");
    end
    $finish;
  end

endmodule
